### hdl/bfsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared types and constants of the shortest path core.
// ----------------------------------------------------------------------------
package bfsp_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int MAX_DEGREE   = 16;
   localparam int WEIGHT_BITS  = 16;
   localparam int VTX_BITS     = $clog2(MAX_VERTICES);
   localparam int SLOT_BITS    = $clog2(MAX_DEGREE);
   localparam int DEG_BITS     = $clog2(MAX_DEGREE + 1);
   localparam int EDGE_BITS    = VTX_BITS + SLOT_BITS;

   localparam logic signed [31:0] UNREACHED_DIST = 32'sd999999;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_RUN    = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_VTX = 2'd1;
   localparam logic [1:0] ST_NO_EDGE = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam logic CSR_VERTEX_COUNT  = 1'b0;
   localparam logic CSR_DIRECTED_MODE = 1'b1;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [5:0]         from_vertex;
      logic [5:0]         to_vertex;
      logic signed [15:0] weight;
      logic [5:0]         source_vertex;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [5:0]         vertex_index;
      logic signed [31:0] distance;
      logic [5:0]         parent_vertex;
      logic               has_parent;
      logic               negative_cycle;
      logic               last;
   } rsp_type;

endpackage
`default_nettype wire

### hdl/bellman_ford_shortest_path_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bellman_ford_shortest_path_core
// Stored-graph single-source shortest path engine.
// ----------------------------------------------------------------------------
// req_ carries commands (add edge, remove edge, run, clear graph); rsp_
// returns one result per command, or one per vertex for a run with the final
// one flagged by last. csr_ writes vertex_count (index 0, clears all lists)
// and directed_mode (index 1) while the core is idle.
// Add writes the edge, in both lists when undirected; remove scans the
// owner's list and, when undirected, the head's list. A run clears the
// table, makes n passes (n-1 relaxing, one check) over each reached
// vertex and its stored edges, then returns one result per vertex. The edge
// loop is set by the edge memory's one read port and the read-compare-write
// on the distance memory.
// One command is in flight at a time.
// Reset: degree counts read as zero through a per-vertex valid vector that
// reset and clear wipe as a whole; req_ready is high right after reset.
// Stall: results wait in the output register and the engine holds.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_path_core
   import bfsp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic    csr_index,
   input  wire logic [6:0] csr_data
);

   // state codes
   localparam logic [4:0] S_IDLE    = 5'd1;
   localparam logic [4:0] S_DEC     = 5'd2;
   localparam logic [4:0] S_ADD2    = 5'd3;
   localparam logic [4:0] S_SCAN    = 5'd4;
   localparam logic [4:0] S_SCANCHK = 5'd5;
   localparam logic [4:0] S_MOVE    = 5'd6;
   localparam logic [4:0] S_MOVEWR  = 5'd7;
   localparam logic [4:0] S_INIT    = 5'd8;
   localparam logic [4:0] S_VTX     = 5'd9;
   localparam logic [4:0] S_VTXCHK  = 5'd10;
   localparam logic [4:0] S_EDGE    = 5'd11;
   localparam logic [4:0] S_EDGEDV  = 5'd12;
   localparam logic [4:0] S_EDGECMP = 5'd13;
   localparam logic [4:0] S_OUTRD   = 5'd14;
   localparam logic [4:0] S_OUT     = 5'd15;
   localparam logic [4:0] S_RESP    = 5'd16;

   logic [4:0] state_ff, state_in;

   // configuration
   logic [6:0] vcount_ff;
   logic       directed_ff;
   logic [6:0] n_eff;
   assign n_eff = (vcount_ff == 7'd0) ? 7'd1 :
                  (vcount_ff > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vcount_ff;

   // degree counts: memory with two registered read ports and a valid vector
   logic [DEG_BITS-1:0]     deg_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] deg_vld_ff;
   logic [DEG_BITS-1:0]     deg_ra_ff, deg_rb_ff;
   logic [VTX_BITS-1:0]     deg_ra_addr, deg_rb_addr;

   // edge memory
   logic [VTX_BITS-1:0]           ehead_mem [MAX_VERTICES*MAX_DEGREE];
   logic signed [WEIGHT_BITS-1:0] ewt_mem   [MAX_VERTICES*MAX_DEGREE];
   logic [EDGE_BITS-1:0]          e_raddr, e_waddr;
   logic                          e_we;
   logic [VTX_BITS-1:0]           e_whead, e_rhead_ff;
   logic signed [WEIGHT_BITS-1:0] e_wwt, e_rwt_ff;

   always_ff @(posedge clock) begin
      if (e_we) begin
         ehead_mem[e_waddr] <= e_whead;
         ewt_mem[e_waddr]   <= e_wwt;
      end
      e_rhead_ff <= ehead_mem[e_raddr];
      e_rwt_ff   <= ewt_mem[e_raddr];
   end

   // vertex memory: distance, reach, parent valid, parent
   localparam int VW = 32 + 2 + VTX_BITS;
   logic [VW-1:0]         v_mem [MAX_VERTICES];
   logic [VTX_BITS-1:0]   v_raddr, v_waddr;
   logic                  v_we;
   logic [VW-1:0]         v_wdata, v_rdata_ff;

   always_ff @(posedge clock) begin
      if (v_we) v_mem[v_waddr] <= v_wdata;
      v_rdata_ff <= v_mem[v_raddr];
   end

   // working registers
   req_type              req_ff;
   logic [1:0]           status_ff, status_in;
   logic [VTX_BITS:0]    vi_ff, vi_in;          // vertex counter
   logic [DEG_BITS-1:0]  k_ff, k_in;            // slot counter
   logic [VTX_BITS:0]    pass_ff, pass_in;
   logic                 neg_ff, neg_in;
   logic                 rev_ff, rev_in;        // reverse-direction phase
   logic [VTX_BITS-1:0]  su_ff, su_in, sv_ff, sv_in;
   logic [SLOT_BITS-1:0] hit_ff, hit_in;
   logic signed [31:0]   du_ff, du_in;
   logic signed [32:0]   cand_ff, cand_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rspv_ff, rspv_in;
   logic                 deg_we, deg_we2;
   logic [VTX_BITS-1:0]  deg_wa, deg_wa2;
   logic [DEG_BITS-1:0]  deg_wd, deg_wd2;
   logic                 deg_clr_all;

   // port a follows the list owner, port b the request's head vertex
   logic [DEG_BITS-1:0] deg_u, deg_v;
   assign deg_u = deg_ra_ff;
   assign deg_v = deg_rb_ff;
   logic [DEG_BITS-1:0] deg_s;
   assign deg_s = deg_ra_ff;

   logic last_pass;
   assign last_pass = ({1'b0, pass_ff} + 8'd1) >= {1'b0, n_eff};

   // saturate the weight
   localparam int WLIM = 1 << (WEIGHT_BITS - 1);
   logic signed [WEIGHT_BITS-1:0] wsat;
   always_comb begin
      if (req_ff.weight > 16'sd0 && 32'(req_ff.weight) > 32'(WLIM - 1))
         wsat = WEIGHT_BITS'(WLIM - 1);
      else if ($signed(32'(req_ff.weight)) < -32'sd0 - 32'(WLIM))
         wsat = WEIGHT_BITS'(-WLIM);
      else
         wsat = WEIGHT_BITS'(req_ff.weight);
   end

   logic signed [32:0] sum33;
   assign sum33 = 33'(du_ff) + 33'(e_rwt_ff);
   logic signed [31:0] sat_sum;
   assign sat_sum = (sum33 > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                    (sum33 < -33'sh0_8000_0000) ? 32'sh8000_0000 : sum33[31:0];

   assign req_ready = (state_ff == S_IDLE) && !rspv_ff;
   assign csr_ready = (state_ff == S_IDLE) && !rspv_ff;
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      vi_in = vi_ff; k_in = k_ff; pass_in = pass_ff; neg_in = neg_ff;
      rev_in = rev_ff; su_in = su_ff; sv_in = sv_ff; hit_in = hit_ff;
      du_in = du_ff; cand_in = cand_ff;
      rsp_in = rsp_ff; rspv_in = rspv_ff;
      e_we = 1'b0; e_waddr = '0; e_whead = '0; e_wwt = '0;
      e_raddr = {su_ff, k_ff[SLOT_BITS-1:0]};
      v_we = 1'b0; v_waddr = '0; v_wdata = '0; v_raddr = vi_ff[VTX_BITS-1:0];
      deg_we = 1'b0; deg_wa = '0; deg_wd = '0;
      deg_we2 = 1'b0; deg_wa2 = '0; deg_wd2 = '0;
      deg_clr_all = 1'b0;

      if (rspv_ff && rsp_ready) rspv_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) state_in = S_DEC;
            if (csr_valid && csr_ready && csr_index == CSR_VERTEX_COUNT)
               deg_clr_all = 1'b1;
         end
         S_DEC: begin
            status_in = ST_OK;
            unique case (req_ff.cmd)
               CMD_ADD: begin
                  if ({1'b0, req_ff.from_vertex} >= n_eff ||
                      {1'b0, req_ff.to_vertex} >= n_eff ||
                      req_ff.from_vertex == req_ff.to_vertex) begin
                     status_in = ST_BAD_VTX; state_in = S_RESP;
                  end else if (deg_u >= DEG_BITS'(MAX_DEGREE) ||
                               (!directed_ff && deg_v >= DEG_BITS'(MAX_DEGREE))) begin
                     status_in = ST_FULL; state_in = S_RESP;
                  end else begin
                     e_we = 1'b1;
                     e_waddr = {req_ff.from_vertex, deg_u[SLOT_BITS-1:0]};
                     e_whead = req_ff.to_vertex; e_wwt = wsat;
                     deg_we = 1'b1; deg_wa = req_ff.from_vertex; deg_wd = deg_u + 1'b1;
                     state_in = directed_ff ? S_RESP : S_ADD2;
                  end
               end
               CMD_REMOVE: begin
                  if ({1'b0, req_ff.from_vertex} >= n_eff ||
                      {1'b0, req_ff.to_vertex} >= n_eff) begin
                     status_in = ST_BAD_VTX; state_in = S_RESP;
                  end else begin
                     su_in = req_ff.from_vertex; sv_in = req_ff.to_vertex;
                     k_in = '0; rev_in = 1'b0; state_in = S_SCAN;
                  end
               end
               CMD_RUN: begin
                  if ({1'b0, req_ff.source_vertex} >= n_eff) begin
                     status_in = ST_BAD_VTX; state_in = S_RESP;
                  end else begin
                     vi_in = '0; state_in = S_INIT;
                  end
               end
               CMD_CLEAR: begin
                  deg_clr_all = 1'b1; state_in = S_RESP;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_ADD2: begin
            e_we = 1'b1;
            e_waddr = {req_ff.to_vertex, deg_v[SLOT_BITS-1:0]};
            e_whead = req_ff.from_vertex; e_wwt = wsat;
            deg_we = 1'b1; deg_wa = req_ff.to_vertex; deg_wd = deg_v + 1'b1;
            state_in = S_RESP;
         end
         // scan list of su for head sv
         S_SCAN: begin
            if (k_ff >= deg_s) begin
               if (!rev_ff) status_in = ST_NO_EDGE;
               state_in = S_RESP;
            end else begin
               state_in = S_SCANCHK;
            end
         end
         S_SCANCHK: begin
            if (e_rhead_ff == sv_ff) begin
               hit_in = k_ff[SLOT_BITS-1:0];
               k_in = deg_s - 1'b1;
               state_in = S_MOVE;
            end else begin
               k_in = k_ff + 1'b1; state_in = S_SCAN;
            end
         end
         S_MOVE: state_in = S_MOVEWR;   // last entry read in flight
         S_MOVEWR: begin
            e_we = 1'b1; e_waddr = {su_ff, hit_ff};
            e_whead = e_rhead_ff; e_wwt = e_rwt_ff;
            deg_we = 1'b1; deg_wa = su_ff; deg_wd = deg_s - 1'b1;
            if (!rev_ff && !directed_ff) begin
               rev_in = 1'b1; su_in = sv_ff; sv_in = su_ff; k_in = '0;
               state_in = S_SCAN;
            end else begin
               state_in = S_RESP;
            end
         end
         // clear the vertex table and mark the source reached
         S_INIT: begin
            v_we = 1'b1; v_waddr = vi_ff[VTX_BITS-1:0];
            v_wdata = (vi_ff[VTX_BITS-1:0] == req_ff.source_vertex) ?
                      {32'sd0, 1'b1, 1'b0, {VTX_BITS{1'b0}}} : '0;
            vi_in = vi_ff + 1'b1;
            if (vi_ff + 1'b1 >= n_eff) begin
               vi_in = '0; pass_in = '0; neg_in = 1'b0; state_in = S_VTX;
            end
         end
         // per vertex: read its distance
         S_VTX: begin
            if (vi_ff >= n_eff) begin
               if (last_pass) begin
                  vi_in = '0; state_in = S_OUTRD;
               end else begin
                  pass_in = pass_ff + 1'b1; vi_in = '0;
               end
            end else begin
               su_in = vi_ff[VTX_BITS-1:0]; k_in = '0; state_in = S_VTXCHK;
            end
         end
         S_VTXCHK: begin
            du_in = v_rdata_ff[VW-1 -: 32];
            if (!v_rdata_ff[VTX_BITS+1]) begin
               vi_in = vi_ff + 1'b1; state_in = S_VTX;
            end else begin
               state_in = S_EDGE;
            end
         end
         // issue edge read
         S_EDGE: begin
            if (k_ff >= deg_s) begin
               vi_in = vi_ff + 1'b1; state_in = S_VTX;
            end else begin
               state_in = S_EDGEDV;
            end
         end
         S_EDGEDV: begin
            if ({1'b0, e_rhead_ff} >= n_eff) begin
               k_in = k_ff + 1'b1; state_in = S_EDGE;
            end else begin
               v_raddr = e_rhead_ff; sv_in = e_rhead_ff;
               cand_in = 33'(sat_sum);
               state_in = S_EDGECMP;
            end
         end
         S_EDGECMP: begin
            k_in = k_ff + 1'b1; state_in = S_EDGE;
            if (!v_rdata_ff[VTX_BITS+1] ||
                $signed(cand_ff[31:0]) < $signed(v_rdata_ff[VW-1 -: 32])) begin
               if (last_pass) neg_in = 1'b1;
               else begin
                  v_we = 1'b1; v_waddr = sv_ff;
                  v_wdata = {cand_ff[31:0], 1'b1, 1'b1, su_ff};
               end
            end
            // reload own distance after a write to the vertex itself
            if (v_we && sv_ff == su_ff) du_in = cand_ff[31:0];
         end
         S_OUTRD: state_in = S_OUT;
         S_OUT: begin
            if (!rspv_ff || rsp_ready) begin
               rspv_in = 1'b1;
               rsp_in.status = ST_OK;
               rsp_in.vertex_index = vi_ff[VTX_BITS-1:0];
               rsp_in.distance = v_rdata_ff[VTX_BITS+1] ?
                                 $signed(v_rdata_ff[VW-1 -: 32]) : UNREACHED_DIST;
               rsp_in.has_parent = v_rdata_ff[VTX_BITS];
               rsp_in.parent_vertex = v_rdata_ff[VTX_BITS] ?
                                      v_rdata_ff[VTX_BITS-1:0] : '0;
               rsp_in.last = (vi_ff + 1'b1 == n_eff);
               rsp_in.negative_cycle = rsp_in.last && neg_ff;
               vi_in = vi_ff + 1'b1;
               state_in = rsp_in.last ? S_IDLE : S_OUTRD;
            end
         end
         S_RESP: begin
            if (!rspv_ff || rsp_ready) begin
               rspv_in = 1'b1;
               rsp_in = '0;
               rsp_in.status = status_ff;
               rsp_in.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // in S_OUTRD the address is vi
      if (state_ff == S_OUTRD) v_raddr = vi_ff[VTX_BITS-1:0];
      // slot read during list walks
      if (state_ff == S_MOVE || (state_ff == S_SCANCHK && e_rhead_ff == sv_ff))
         e_raddr = {su_ff, k_in[SLOT_BITS-1:0]};
      deg_wa2 = deg_wa; deg_wd2 = deg_wd; deg_we2 = deg_we;
      // degree reads are registered ahead of the state that uses them
      deg_ra_addr = (state_ff == S_IDLE) ? req_data.from_vertex : su_in;
      deg_rb_addr = (state_ff == S_IDLE) ? req_data.to_vertex : req_ff.to_vertex;
   end

   // degree count storage with write and clear forwarding on the reads
   always_ff @(posedge clock) begin
      if (deg_we2) deg_mem[deg_wa2] <= deg_wd2;
      if (deg_clr_all) deg_ra_ff <= '0;
      else if (deg_we2 && deg_wa2 == deg_ra_addr) deg_ra_ff <= deg_wd2;
      else deg_ra_ff <= deg_vld_ff[deg_ra_addr] ? deg_mem[deg_ra_addr] : '0;
      if (deg_clr_all) deg_rb_ff <= '0;
      else if (deg_we2 && deg_wa2 == deg_rb_addr) deg_rb_ff <= deg_wd2;
      else deg_rb_ff <= deg_vld_ff[deg_rb_addr] ? deg_mem[deg_rb_addr] : '0;
   end

   // written since the last reset or clear
   always_ff @(posedge clock) begin
      if (reset || deg_clr_all) deg_vld_ff <= '0;
      else if (deg_we2) deg_vld_ff[deg_wa2] <= 1'b1;
   end

   // control and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vi_ff <= '0;
         rspv_ff <= 1'b0;
         vcount_ff <= 7'd64;
         directed_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         vi_ff <= vi_in;
         rspv_ff <= rspv_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_VERTEX_COUNT) vcount_ff <= csr_data;
            else directed_ff <= csr_data[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_data;
      status_ff <= status_in; k_ff <= k_in; pass_ff <= pass_in;
      neg_ff <= neg_in; rev_ff <= rev_in; su_ff <= su_in; sv_ff <= sv_in;
      hit_ff <= hit_in; du_ff <= du_in; cand_ff <= cand_in; rsp_ff <= rsp_in;
   end

endmodule
`default_nettype wire

### sim/bellman_ford_shortest_path_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bellman_ford_shortest_path_checker
// Watches the command, result and register channels of the shortest path
// core. It keeps its own copy of the graph, predicts every result of each
// accepted command and compares the results in order, field by field.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_path_checker
   import bfsp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire req_type    req_data,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire rsp_type    rsp_data,
   input  wire logic       csr_valid,
   input  wire logic       csr_ready,
   input  wire logic       csr_index,
   input  wire logic [6:0] csr_data,
   output int              error_count,
   output int              pending_count,
   output int              result_count
);

   // graph copy and register copy
   logic [6:0]  vertex_count;
   logic        directed_mode;
   int          degree [MAX_VERTICES];
   logic [5:0]  edge_head [MAX_VERTICES][MAX_DEGREE];
   int          edge_weight [MAX_VERTICES][MAX_DEGREE];

   // per-run tables
   longint      path_dist [MAX_VERTICES];
   bit          reached [MAX_VERTICES];
   logic [5:0]  path_parent [MAX_VERTICES];
   bit          parent_known [MAX_VERTICES];

   rsp_type     expected_rsp [$];

   assign pending_count = expected_rsp.size();

   function automatic int active_vertices();
      if (vertex_count < 1) return 1;
      if (vertex_count > MAX_VERTICES) return MAX_VERTICES;
      return int'(vertex_count);
   endfunction

   function automatic int find_slot(int u, int v);
      for (int k = 0; k < degree[u]; k++)
         if (edge_head[u][k] == v) return k;
      return -1;
   endfunction

   // drop slot k, moving the last entry into its place
   function automatic void drop_slot(int u, int k);
      edge_head[u][k] = edge_head[u][degree[u] - 1];
      edge_weight[u][k] = edge_weight[u][degree[u] - 1];
      degree[u]--;
   endfunction

   function automatic void append_edge(int u, int v, int w);
      edge_head[u][degree[u]] = v[5:0];
      edge_weight[u][degree[u]] = w;
      degree[u]++;
   endfunction

   // one sweep over every stored edge; relaxes, or only detects an improvement
   function automatic bit relax_sweep(int n, bit apply);
      bit     improved;
      int     v;
      longint cand;
      improved = 0;
      for (int u = 0; u < n; u++) begin
         for (int k = 0; k < degree[u]; k++) begin
            v = int'(edge_head[u][k]);
            if (v >= n || !reached[u]) continue;
            cand = path_dist[u] + edge_weight[u][k];
            if (cand > 64'sd2147483647) cand = 64'sd2147483647;
            if (cand < -64'sd2147483648) cand = -64'sd2147483648;
            if (!reached[v] || cand < path_dist[v]) begin
               if (!apply) begin
                  improved = 1;
                  continue;
               end
               path_dist[v] = cand;
               reached[v] = 1;
               path_parent[v] = u[5:0];
               parent_known[v] = 1;
            end
         end
      end
      return improved;
   endfunction

   // expected results of one accepted command
   function automatic void predict_command(req_type r);
      int      n, u, v, k;
      bit      neg;
      rsp_type o;
      n = active_vertices();
      u = int'(r.from_vertex);
      v = int'(r.to_vertex);
      o = '0;
      o.last = 1'b1;
      if (r.cmd == CMD_RUN && r.source_vertex < n) begin
         for (int i = 0; i < n; i++) begin
            reached[i] = 0;
            parent_known[i] = 0;
            path_parent[i] = '0;
            path_dist[i] = 0;
         end
         reached[r.source_vertex] = 1;
         for (int i = 0; i + 1 < n; i++) void'(relax_sweep(n, 1));
         neg = relax_sweep(n, 0);
         for (int i = 0; i < n; i++) begin
            o = '0;
            o.status = ST_OK;
            o.vertex_index = i[5:0];
            o.distance = reached[i] ? 32'(path_dist[i]) : UNREACHED_DIST;
            o.parent_vertex = parent_known[i] ? path_parent[i] : 6'd0;
            o.has_parent = parent_known[i];
            o.negative_cycle = (i + 1 == n) && neg;
            o.last = (i + 1 == n);
            expected_rsp.push_back(o);
         end
         return;
      end
      case (r.cmd)
         CMD_ADD: begin
            if (u >= n || v >= n || u == v) o.status = ST_BAD_VTX;
            else if (degree[u] >= MAX_DEGREE || (!directed_mode && degree[v] >= MAX_DEGREE))
               o.status = ST_FULL;
            else begin
               append_edge(u, v, int'(r.weight));
               if (!directed_mode) append_edge(v, u, int'(r.weight));
            end
         end
         CMD_REMOVE: begin
            if (u >= n || v >= n) o.status = ST_BAD_VTX;
            else begin
               k = find_slot(u, v);
               if (k < 0) o.status = ST_NO_EDGE;
               else begin
                  drop_slot(u, k);
                  if (!directed_mode) begin
                     k = find_slot(v, u);
                     if (k >= 0) drop_slot(v, k);
                  end
               end
            end
         end
         CMD_CLEAR: foreach (degree[i]) degree[i] = 0;
         default: o.status = ST_BAD_VTX;
      endcase
      expected_rsp.push_back(o);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("tb: mismatch %s got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic compare_field(string what, longint got, longint want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   // watch all three channels
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         vertex_count = 7'd64;
         directed_mode = 1'b1;
         foreach (degree[i]) degree[i] = 0;
         expected_rsp.delete();
         error_count = 0;
         result_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_VERTEX_COUNT) begin
               vertex_count = csr_data;
               foreach (degree[i]) degree[i] = 0;
            end else directed_mode = csr_data[0];
         end
         if (req_valid && req_ready) predict_command(req_data);
         if (rsp_valid && rsp_ready) begin
            result_count <= result_count + 1;
            if (expected_rsp.size() == 0) report_mismatch("unexpected transfer", 0, 0);
            else begin
               want = expected_rsp.pop_front();
               compare_field("status", rsp_data.status, want.status);
               compare_field("vertex_index", rsp_data.vertex_index, want.vertex_index);
               compare_field("distance", rsp_data.distance, want.distance);
               compare_field("parent_vertex", rsp_data.parent_vertex, want.parent_vertex);
               compare_field("has_parent", rsp_data.has_parent, want.has_parent);
               compare_field("negative_cycle", rsp_data.negative_cycle,
                             want.negative_cycle);
               compare_field("last", rsp_data.last, want.last);
            end
         end
      end
   end

endmodule

### sim/bellman_ford_shortest_path_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bellman_ford_shortest_path_core_tb
// Drives commands and register writes into the shortest path core with
// random gaps and back pressure; a checker beside the core predicts and
// compares every result.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_path_core_tb;
   import bfsp_pkg::*;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = 1'b0;
   logic [6:0] csr_data = '0;

   int         error_count, pending_count, result_count;
   int         cycle_count = 0;
   int         hold_cycles = 0;
   int         commands_sent = 0;
   int         settings_used = 0;
   bit         calm;

   bellman_ford_shortest_path_core u_top (.*);

   bellman_ford_shortest_path_checker u_checker (.*);

   always #2 clock = ~clock;

   // no idling at all in one long window
   assign calm = cycle_count >= 4000 && cycle_count < 9000;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // result side: random idling plus one long hold-off
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready && result_count == 30) begin
         hold_cycles <= 600;
         rsp_ready <= 1'b0;
      end else rsp_ready <= calm || $urandom_range(99) >= 16;
   end

   task automatic send_command(logic [1:0] cmd, int u, int v, int w, int src);
      req_type r;
      r.cmd = cmd;
      r.from_vertex = u[5:0];
      r.to_vertex = v[5:0];
      r.weight = w[15:0];
      r.source_vertex = src[5:0];
      while (!calm && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      commands_sent++;
   endtask

   // register write once the core has drained
   task automatic write_register(logic idx, logic [6:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // random vertex: mostly inside the active range
   function automatic int pick_vertex(int n);
      if ($urandom_range(99) < 8) return $urandom_range(63);
      return $urandom_range(n - 1);
   endfunction

   function automatic int pick_weight();
      if ($urandom_range(99) < 20) return $urandom;
      return $urandom_range(250) - 50;
   endfunction

   initial begin
      int n, roll;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part, reset setting: 64 vertices, directed
      send_command(CMD_ADD, 0, 1, 32767, 0);
      send_command(CMD_ADD, 1, 2, -32768, 0);
      send_command(CMD_ADD, 0, 0, 5, 0);
      send_command(CMD_ADD, 0, 63, 7, 0);
      send_command(CMD_REMOVE, 1, 0, 0, 0);
      send_command(CMD_RUN, 0, 0, 0, 0);
      send_command(CMD_RUN, 63, 63, -1, 63);
      send_command(CMD_CLEAR, 0, 0, 0, 0);
      for (int i = 0; i < 17; i++) send_command(CMD_ADD, 3, 4 + i, i, 0);
      send_command(CMD_REMOVE, 3, 4, 0, 0);

      // single vertex, then the clamp from above, undirected
      write_register(CSR_VERTEX_COUNT, 7'd0);
      send_command(CMD_RUN, 0, 0, 0, 0);
      send_command(CMD_RUN, 0, 0, 0, 1);
      send_command(CMD_ADD, 0, 1, 1, 0);
      write_register(CSR_DIRECTED_MODE, 1'b0);
      write_register(CSR_VERTEX_COUNT, 7'd127);
      send_command(CMD_ADD, 62, 63, -3, 0);
      send_command(CMD_REMOVE, 63, 62, 0, 0);

      // negative cycle through an undirected edge, then mode flip
      write_register(CSR_VERTEX_COUNT, 7'd5);
      send_command(CMD_ADD, 0, 1, -5, 0);
      send_command(CMD_ADD, 1, 4, 9, 0);
      send_command(CMD_RUN, 0, 0, 0, 0);
      send_command(CMD_RUN, 0, 0, 0, 5);
      write_register(CSR_DIRECTED_MODE, 1'b1);
      send_command(CMD_REMOVE, 1, 0, 0, 0);
      send_command(CMD_RUN, 0, 0, 0, 4);

      // random phases with fresh settings
      for (int p = 0; p < 6; p++) begin
         n = (p == 3) ? 64 : $urandom_range(10, 2);
         write_register(CSR_DIRECTED_MODE, 7'($urandom_range(1)));
         write_register(CSR_VERTEX_COUNT, n[6:0]);
         for (int i = 0; i < 11; i++) begin
            roll = $urandom_range(99);
            if (roll < 55)
               send_command(CMD_ADD, pick_vertex(n), pick_vertex(n), pick_weight(), 0);
            else if (roll < 75)
               send_command(CMD_REMOVE, pick_vertex(n), pick_vertex(n), $urandom, 0);
            else if (roll < 96)
               send_command(CMD_RUN, $urandom, $urandom, $urandom, pick_vertex(n));
            else send_command(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
         end
      end

      // drain
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("tb: %0d commands, %0d results, %0d register writes", commands_sent,
               result_count, settings_used);
      $display("tb: covered bad vertices, full lists, missing edges, negative cycles");
      if (error_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   // run limit
   initial begin
      #40_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
